[rtl/core/bba_pkg.sv]
package bba_pkg;

   localparam int FIELD_W           = 14;
   localparam int WORD_BITS         = 32;
   localparam int BIT_IDX_W         = 5;
   localparam int ENTRY_COUNT_RESET = 8192;

   typedef enum logic {
      CMD_ALLOC   = 1'b0,
      CMD_RELEASE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_RANGE     = 2'd1,
      STATUS_NOT_ALLOC = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic check;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic start_alloc;
      logic start_direct;
      logic scan_hit;
      logic last_word;
      logic out_busy;
   } ctrl_status_type;

endpackage

[rtl/core/bba_intf.sv]
interface bba_req_if;
   logic                         valid;
   logic                         ready;
   bba_pkg::cmd_type             cmd;
   logic [bba_pkg::FIELD_W-1:0]  entry_number;

   modport source (output valid, cmd, entry_number, input ready);
   modport sink (input valid, cmd, entry_number, output ready);
endinterface

interface bba_rsp_if;
   logic                         valid;
   logic                         ready;
   bba_pkg::status_type          status;
   logic [bba_pkg::FIELD_W-1:0]  granted_number;
   logic [bba_pkg::FIELD_W-1:0]  free_count;

   modport source (output valid, status, granted_number, free_count, input ready);
   modport sink (input valid, status, granted_number, free_count, output ready);
endinterface

interface bba_csr_if;
   logic                         valid;
   logic                         ready;
   logic [bba_pkg::FIELD_W-1:0]  data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

[rtl/core/bba_ram.sv]
module bba_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/bba_datapath.sv]
module bba_datapath #(
   parameter int MAX_ENTRIES = 8192
) (
   input  logic                         clock,
   input  logic                         reset,
   input  bba_pkg::ctrl_cmd_type        cmd,
   output bba_pkg::ctrl_status_type     status,
   input  bba_pkg::cmd_type             req_cmd,
   input  logic [bba_pkg::FIELD_W-1:0]  req_entry_number,
   input  logic                         csr_valid,
   input  logic [bba_pkg::FIELD_W-1:0]  csr_data,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output bba_pkg::status_type          rsp_status,
   output logic [bba_pkg::FIELD_W-1:0]  rsp_granted_number,
   output logic [bba_pkg::FIELD_W-1:0]  rsp_free_count
);

   import bba_pkg::*;

   localparam int WORDS   = (MAX_ENTRIES + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W  = $clog2(WORDS);
   localparam int ENTRY_W = ADDR_W + BIT_IDX_W;
   localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W   = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;
   localparam int HWM_W   = $clog2(WORDS + 1);

   logic [FIELD_W-1:0]   entry_count_ff, entry_count_in;
   logic [CMP_W-1:0]     count_ext, cap_ext, lim_ext;
   logic [CNT_W-1:0]     lim, lim_m1;
   logic [ADDR_W-1:0]    last_word;
   logic [CMP_W-1:0]     num_ext, num_m1;
   logic                 rel_oor;
   logic [ADDR_W-1:0]    rel_word;
   logic [BIT_IDX_W-1:0] rel_bit_ff, rel_bit_in;
   logic [ADDR_W-1:0]    rd_addr;
   logic [ADDR_W-1:0]    rd_addr_ff, rd_addr_in;
   logic [ADDR_W-1:0]    eval_addr_ff, eval_addr_in;
   logic                 in_range_ff, in_range_in;
   logic [HWM_W-1:0]     hwm_ff, hwm_in;
   logic [WORD_BITS-1:0] rd_data, word, valid_mask, free_bits, wr_data;
   logic                 wr_en, rd_en;
   logic [CNT_W-1:0]     base, remain;
   logic [BIT_IDX_W-1:0] free_idx;
   logic                 scan_hit, rel_hit;
   logic [ENTRY_W:0]     grant_sum;
   logic [CNT_W-1:0]     used_ff, used_in;
   status_type           status_ff, status_in;
   logic [FIELD_W-1:0]   granted_ff, granted_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [FIELD_W-1:0]   rsp_granted_ff, rsp_granted_in;
   logic [FIELD_W-1:0]   rsp_free_ff, rsp_free_in;

   // The bitmap is kept in 32-bit words; words at or above the high-water mark were
   // never written and read as all free.
   bba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (eval_addr_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      count_ext = CMP_W'(entry_count_ff);
      cap_ext   = CMP_W'(MAX_ENTRIES);
      lim_ext   = (count_ext > cap_ext) ? cap_ext : count_ext;
      lim       = CNT_W'(lim_ext);
      lim_m1    = lim - CNT_W'(1);
      last_word = lim_m1[ENTRY_W-1:BIT_IDX_W];

      num_ext  = CMP_W'(req_entry_number);
      num_m1   = num_ext - CMP_W'(1);
      rel_oor  = (num_ext == '0) || (num_ext > lim_ext);
      rel_word = num_m1[ENTRY_W-1:BIT_IDX_W];
   end

   always_comb begin
      rd_en   = cmd.start | cmd.scan;
      rd_addr = rd_addr_ff;
      if (cmd.start) begin
         rd_addr = (req_cmd == CMD_ALLOC) ? '0 : rel_word;
      end
   end

   always_comb begin
      word       = rd_data & {WORD_BITS{in_range_ff}};
      base       = CNT_W'({eval_addr_ff, BIT_IDX_W'(0)});
      remain     = lim - base;
      valid_mask = (remain >= CNT_W'(WORD_BITS)) ? '1 :
                   ~({WORD_BITS{1'b1}} << remain[BIT_IDX_W-1:0]);
      free_bits  = ~word & valid_mask;
      free_idx   = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            free_idx = BIT_IDX_W'(i);
         end
      end
      scan_hit  = |free_bits;
      rel_hit   = word[rel_bit_ff];
      grant_sum = (ENTRY_W + 1)'({eval_addr_ff, free_idx}) + (ENTRY_W + 1)'(1);
      wr_en     = (cmd.scan & scan_hit) | (cmd.check & rel_hit);
      wr_data   = cmd.scan ? (word | (WORD_BITS'(1) << free_idx))
                           : (word & ~(WORD_BITS'(1) << rel_bit_ff));
   end

   always_comb begin
      entry_count_in = csr_valid ? csr_data : entry_count_ff;
      rd_addr_in     = rd_addr_ff;
      eval_addr_in   = eval_addr_ff;
      in_range_in    = in_range_ff;
      rel_bit_in     = rel_bit_ff;
      hwm_in         = hwm_ff;
      used_in        = used_ff;
      status_in      = status_ff;
      granted_in     = granted_ff;

      if (cmd.start | cmd.scan) begin
         rd_addr_in   = rd_addr + ADDR_W'(1);
         eval_addr_in = rd_addr;
         in_range_in  = HWM_W'(rd_addr) < hwm_ff;
      end
      if (cmd.start) begin
         rel_bit_in = num_m1[BIT_IDX_W-1:0];
         status_in  = (req_cmd == CMD_ALLOC) ? STATUS_FULL : STATUS_RANGE;
         granted_in = '0;
      end
      if (cmd.scan && scan_hit) begin
         status_in  = STATUS_OK;
         granted_in = FIELD_W'(grant_sum);
         used_in    = used_ff + CNT_W'(1);
         if (HWM_W'(eval_addr_ff) == hwm_ff) begin
            hwm_in = hwm_ff + HWM_W'(1);
         end
      end
      if (cmd.check) begin
         if (rel_hit) begin
            status_in = STATUS_OK;
            if (used_ff != '0) begin
               used_in = used_ff - CNT_W'(1);
            end
         end else begin
            status_in = STATUS_NOT_ALLOC;
         end
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_free_in    = rsp_free_ff;
      if (cmd.finish) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = status_ff;
         rsp_granted_in = granted_ff;
         rsp_free_in    = (lim > used_ff) ? FIELD_W'(lim - used_ff) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= FIELD_W'(ENTRY_COUNT_RESET);
         hwm_ff         <= '0;
         used_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         entry_count_ff <= entry_count_in;
         hwm_ff         <= hwm_in;
         used_ff        <= used_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff     <= rd_addr_in;
      eval_addr_ff   <= eval_addr_in;
      in_range_ff    <= in_range_in;
      rel_bit_ff     <= rel_bit_in;
      status_ff      <= status_in;
      granted_ff     <= granted_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_free_ff    <= rsp_free_in;
   end

   assign status.start_alloc  = (req_cmd == CMD_ALLOC);
   assign status.start_direct = (req_cmd == CMD_ALLOC) ? (lim == '0) : rel_oor;
   assign status.scan_hit     = scan_hit;
   assign status.last_word    = (eval_addr_ff == last_word);
   assign status.out_busy     = rsp_valid_ff & ~rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_granted_number = rsp_granted_ff;
   assign rsp_free_count     = rsp_free_ff;

endmodule

[rtl/core/bba_controller.sv]
module bba_controller (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  bba_pkg::ctrl_status_type  status,
   output bba_pkg::ctrl_cmd_type     cmd
);

   import bba_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (status.start_direct) begin
                  state_in = ST_DONE;
               end else if (status.start_alloc) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_SCAN: begin
            if (status.scan_hit || status.last_word) begin
               state_in = ST_DONE;
            end
         end
         ST_CHECK: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!status.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd.start  = 1'b0;
      cmd.scan   = 1'b0;
      cmd.check  = 1'b0;
      cmd.finish = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
         end
         ST_DONE: begin
            cmd.finish = ~status.out_busy;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/block_bitmap_allocator_top.sv]
// First-fit bitmap allocator. An allocate beat grants the lowest free entry below the
// configured entry count and returns its one-based number; a release beat frees a
// one-based entry after range and ownership checks. The bitmap sits in a RAM of
// 32-bit words and the allocate scan reads one word per cycle, examining up to
// ceil(min(entry_count, MAX_ENTRIES) / 32) words; a release checks the one word that
// holds its entry, and a rejected beat goes straight to its result. A finished result
// waits in an output register while the next beat is taken. The bitmap reads as all
// free after reset with no clearing pass, because words beyond a high-water mark of
// written words are treated as empty.
module block_bitmap_allocator_top #(
   parameter int MAX_ENTRIES = 8192
) (
   input logic      clock,
   input logic      reset,
   bba_req_if.sink  req_chan,
   bba_rsp_if.source rsp_chan,
   bba_csr_if.sink  csr_chan
);

   import bba_pkg::*;

   ctrl_cmd_type    ctrl_cmd;
   ctrl_status_type ctrl_status;

   assign csr_chan.ready = 1'b1;

   bba_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (ctrl_status),
      .cmd       (ctrl_cmd)
   );

   bba_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (ctrl_cmd),
      .status             (ctrl_status),
      .req_cmd            (req_chan.cmd),
      .req_entry_number   (req_chan.entry_number),
      .csr_valid          (csr_chan.valid),
      .csr_data           (csr_chan.data),
      .rsp_ready          (rsp_chan.ready),
      .rsp_valid          (rsp_chan.valid),
      .rsp_status         (rsp_chan.status),
      .rsp_granted_number (rsp_chan.granted_number),
      .rsp_free_count     (rsp_chan.free_count)
   );

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl_cmd.start, ctrl_cmd.scan, ctrl_cmd.check, ctrl_cmd.finish}))
      else $error("More than one datapath command is active.");

   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("A new beat was taken while one is in progress.");

   assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.finish |=> rsp_chan.valid)
      else $error("A finished beat did not reach the output register.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.granted_number != '0) |-> rsp_chan.status == STATUS_OK)
      else $error("A grant was returned with an error status.");
`endif

endmodule
